@@ src/stbs_pkg.sv @@
`timescale 1ns / 1ps
// Package with the fixed field widths and item codes of the sorted table binary search.
package stbs_pkg;

  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  localparam logic signed [POS_W-1:0] NOT_FOUND = '1;

endpackage

@@ src/sorted_table_binary_search.sv @@
`timescale 1ns / 1ps
// Sorted table binary search: a write item stores one signed word in the table and gives no
// result. A search item probes the midpoint of its inclusive range and narrows the range until it
// finds an equal entry or the range empties, then gives the index or -1. Each probe takes a
// synchronous table read and then a compare; an empty range gives -1 without a probe. The next
// item is taken once the result sits in the output register, even while the result still waits
// to be taken. Searched entries must have been written and be ascending.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [stbs_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] entry_value,
  input  logic signed [stbs_pkg::VALUE_W-1:0] target,
  input  logic [stbs_pkg::INDEX_W-1:0]        low_bound,
  input  logic signed [stbs_pkg::POS_W-1:0]   high_bound,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [stbs_pkg::POS_W-1:0]   position
);

  localparam int IW = stbs_pkg::INDEX_W;
  localparam int BW = stbs_pkg::POS_W + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                       state;
  logic signed [BW-1:0]             lo;
  logic signed [BW-1:0]             hi;
  logic signed [WORD_WIDTH-1:0]     key;
  logic [IW-1:0]                    mid;
  logic signed [stbs_pkg::POS_W-1:0] result;

  logic                             accept;
  logic                             wr_en;
  logic                             rd_en;
  logic [IW:0]                      mid_sum;
  logic [IW-1:0]                    mid_calc;
  logic signed [WORD_WIDTH-1:0]     rd_data;
  logic signed [WORD_WIDTH-1:0]     wr_word;
  logic signed [BW-1:0]             lo_in;
  logic signed [BW-1:0]             hi_in;
  logic signed [BW-1:0]             lo_next;
  logic signed [BW-1:0]             hi_next;
  logic                             hit;
  logic                             go_low;
  logic                             out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_en    = accept && (mode == stbs_pkg::MODE_WRITE);
  assign rd_en    = (state == S_READ);
  assign out_free = !out_valid || !out_stall;

  // Words are held at the table width, sign-extended or cut from the port width.
  assign wr_word = WORD_WIDTH'(entry_value);

  assign lo_in = $signed({2'b00, low_bound});
  assign hi_in = BW'(high_bound);

  // Inside the loop both bounds lie in the index range, so the midpoint is the halved sum.
  assign mid_sum  = {1'b0, lo[IW-1:0]} + {1'b0, hi[IW-1:0]};
  assign mid_calc = mid_sum[IW:1];

  assign hit     = (rd_data == key);
  assign go_low  = (rd_data > key);
  assign lo_next = go_low ? lo : ($signed({2'b00, mid}) + BW'(1));
  assign hi_next = go_low ? ($signed({2'b00, mid}) - BW'(1)) : hi;

  stbs_table #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WORD_WIDTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_index),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (mid_calc),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && (mode == stbs_pkg::MODE_SEARCH)) begin
            if (hi_in < lo_in) begin
              state <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit || (lo_next > hi_next)) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A new result may load in the same cycle that the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lo     <= lo_in;
        hi     <= hi_in;
        key    <= WORD_WIDTH'(target);
        result <= stbs_pkg::NOT_FOUND;
      end
      S_READ: begin
        mid <= mid_calc;
      end
      S_CMP: begin
        lo <= lo_next;
        hi <= hi_next;
        if (hit) begin
          result <= $signed({1'b0, mid});
        end
      end
      S_DONE: begin
        if (out_free) begin
          position <= result;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/stbs_table.sv @@
`timescale 1ns / 1ps
// Table memory with one write port and one registered read port, out-of-range reads give zero.
module stbs_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [stbs_pkg::INDEX_W-1:0]     wr_addr,
  input  logic signed [WIDTH-1:0]          wr_data,
  input  logic                             rd_en,
  input  logic [stbs_pkg::INDEX_W-1:0]     rd_addr,
  output logic signed [WIDTH-1:0]          rd_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int IDX_W = (AW > stbs_pkg::INDEX_W) ? AW : stbs_pkg::INDEX_W;

  logic signed [WIDTH-1:0] mem [DEPTH];
  logic signed [WIDTH-1:0] rd_q;
  logic                    rd_oor;
  logic [IDX_W-1:0]        wr_wide;
  logic [IDX_W-1:0]        rd_wide;
  logic                    wr_ok;
  logic                    rd_ok;

  assign wr_wide = IDX_W'(wr_addr);
  assign rd_wide = IDX_W'(rd_addr);
  assign wr_ok = (32'(wr_addr) < 32'(DEPTH));
  assign rd_ok = (32'(rd_addr) < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_wide[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_wide[AW-1:0]];
      rd_oor <= !rd_ok;
    end
  end

  // Positions past the end of a short table read as zero.
  assign rd_data = rd_oor ? '0 : rd_q;

endmodule

@@ src/stbs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the sorted table binary search and their binding to the top level.
module stbs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              mode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [stbs_pkg::POS_W-1:0] position
);

  // A result that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position))
    else $error("stalled result changed or dropped");

  // A write transfer never brings a result in the next cycle.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == stbs_pkg::MODE_WRITE) && !out_valid |=> !out_valid)
    else $error("write transfer produced a result");

  // A search keeps the input side closed at least for the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == stbs_pkg::MODE_SEARCH) |=> in_stall)
    else $error("input taken while a search runs");

  // A result is either not found or a non-negative index.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !position[stbs_pkg::POS_W-1] || (position == stbs_pkg::NOT_FOUND))
    else $error("result position out of range");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
